// ----- rtl/tccs_pkg.sv -----
// Shared types and constants for the text console screen engine.
package tccs_pkg;

   typedef logic [15:0] cell_type;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // white-on-black blank
   localparam cell_type BLANK_CELL = 16'h0F20;

endpackage

// ----- rtl/tccs_cell_ram.sv -----
// Screen cell store: one write port, one read port with registered data.
module tccs_cell_ram #(
   parameter int DEPTH      = 2000,
   parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [ADDR_WIDTH-1:0]   wr_addr,
   input  tccs_pkg::cell_type      wr_data,
   input  logic                    rd_en,
   input  logic [ADDR_WIDTH-1:0]   rd_addr,
   output tccs_pkg::cell_type      rd_data
);

   tccs_pkg::cell_type mem [DEPTH];
   tccs_pkg::cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/text_console_cursor_and_screen.sv -----
// Flow: ST_EXEC runs a latched item, then ST_FINISH loads the free output register;
// clear sweeps every cell in ST_FILL; a scrolling put moves each cell up one row
// (ST_SCR_RD, ST_SCR_WR) and blanks the bottom row. One item at a time: req_stall is
// high outside ST_IDLE. Reset (synchronous): cursor homes, then a clearing pass over
// all COLUMNS*ROWS cells (2000 by default) writes blanks while req_stall stays high.
module text_console_cursor_and_screen #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_char_code,
   input  logic [3:0]  req_back_color,
   input  logic [3:0]  req_fore_color,
   input  logic [10:0] req_cell_index,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [10:0] rsp_cursor_position,
   output logic [4:0]  rsp_cursor_row,
   output logic [6:0]  rsp_cursor_column,
   output logic        rsp_scrolled,
   output logic [15:0] rsp_cell_word
);

   localparam int CELLS        = COLUMNS * ROWS;
   localparam int AW           = $clog2(CELLS);
   localparam int RW           = $clog2(ROWS);
   localparam int CW           = $clog2(COLUMNS);
   localparam int SCROLL_CELLS = (ROWS - 1) * COLUMNS;

   typedef enum logic [2:0] {
      ST_INIT,    // post-reset clearing pass
      ST_IDLE,    // ready for a transfer
      ST_EXEC,    // decode and run the latched item
      ST_FILL,    // clear-screen sweep
      ST_SCR_RD,  // scroll: fetch cell one row below, or blank the bottom row
      ST_SCR_WR,  // scroll: store fetched cell
      ST_FINISH   // hand result to output register
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        cnt_ff, cnt_in;
   logic [RW-1:0]        row_ff, row_in;
   logic [CW-1:0]        col_ff, col_in;
   logic [AW-1:0]        pos_ff, pos_in;     // always row*COLUMNS + col
   logic                 scrolled_ff, scrolled_in;
   logic                 hit_ff, hit_in;     // read landed inside the screen
   tccs_pkg::opcode_type op_ff, op_in;
   logic [7:0]           ch_ff, ch_in;
   logic [7:0]           attr_ff, attr_in;
   logic [10:0]          idx_ff, idx_in;
   tccs_pkg::cell_type   fill_ff, fill_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [10:0]          rsp_pos_ff, rsp_pos_in;
   logic [4:0]           rsp_row_ff, rsp_row_in;
   logic [6:0]           rsp_col_ff, rsp_col_in;
   logic                 rsp_scr_ff, rsp_scr_in;
   logic [15:0]          rsp_word_ff, rsp_word_in;

   // store port controls
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   tccs_pkg::cell_type   wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   tccs_pkg::cell_type   rd_data;

   // cursor arithmetic for put-char
   logic [CW:0]          col_inc;
   logic [RW:0]          row_inc;
   logic [RW:0]          row_w;
   logic [AW:0]          pos_w;

   tccs_cell_ram #(
      .DEPTH      (CELLS),
      .ADDR_WIDTH (AW)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      pos_in       = pos_ff;
      scrolled_in  = scrolled_ff;
      hit_in       = hit_ff;
      op_in        = op_ff;
      ch_in        = ch_ff;
      attr_in      = attr_ff;
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_scr_in   = rsp_scr_ff;
      rsp_word_in  = rsp_word_ff;
      wr_en        = 1'b0;
      wr_addr      = cnt_ff;
      wr_data      = fill_ff;
      rd_en        = 1'b0;
      rd_addr      = AW'(cnt_ff + AW'(COLUMNS));
      col_inc      = {1'b0, col_ff} + (CW+1)'(1);
      row_inc      = {1'b0, row_ff} + (RW+1)'(1);
      row_w        = {1'b0, row_ff};
      pos_w        = {1'b0, pos_ff};

      // output register drains on a transfer
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = tccs_pkg::BLANK_CELL;
            if (cnt_ff == AW'(CELLS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               op_in       = tccs_pkg::opcode_type'(req_opcode);
               ch_in       = req_char_code;
               attr_in     = {req_back_color, req_fore_color};
               idx_in      = req_cell_index;
               scrolled_in = 1'b0;
               hit_in      = 1'b0;
               state_in    = ST_EXEC;
            end
         end

         ST_EXEC: begin
            unique case (op_ff)
               tccs_pkg::OP_PUT: begin
                  if (ch_ff == tccs_pkg::CHAR_CR) begin
                     col_in = '0;
                     pos_w  = {1'b0, pos_ff} - (AW+1)'(col_ff);
                  end else if (ch_ff == tccs_pkg::CHAR_LF) begin
                     col_in = '0;
                     row_w  = row_inc;
                     pos_w  = {1'b0, pos_ff} - (AW+1)'(col_ff) + (AW+1)'(COLUMNS);
                  end else begin
                     // printable: store at cursor, then advance with row wrap
                     wr_en   = 1'b1;
                     wr_addr = pos_ff;
                     wr_data = {attr_ff, ch_ff};
                     pos_w   = {1'b0, pos_ff} + (AW+1)'(1);
                     if (col_inc == (CW+1)'(COLUMNS)) begin
                        col_in = '0;
                        row_w  = row_inc;
                     end else begin
                        col_in = col_inc[CW-1:0];
                     end
                  end
                  if (row_w == (RW+1)'(ROWS)) begin
                     // ran off the bottom: scroll and park on the last row
                     row_in      = RW'(ROWS - 1);
                     pos_in      = AW'(pos_w - (AW+1)'(COLUMNS));
                     scrolled_in = 1'b1;
                     cnt_in      = '0;
                     state_in    = ST_SCR_RD;
                  end else begin
                     row_in   = row_w[RW-1:0];
                     pos_in   = pos_w[AW-1:0];
                     state_in = ST_FINISH;
                  end
               end
               tccs_pkg::OP_CLEAR: begin
                  fill_in  = {attr_ff, tccs_pkg::CHAR_SPACE};
                  row_in   = '0;
                  col_in   = '0;
                  pos_in   = '0;
                  cnt_in   = '0;
                  state_in = ST_FILL;
               end
               tccs_pkg::OP_READ: begin
                  hit_in   = (32'(idx_ff) < 32'(CELLS));
                  rd_en    = (32'(idx_ff) < 32'(CELLS));
                  rd_addr  = AW'(idx_ff);
                  state_in = ST_FINISH;
               end
               default: begin
                  state_in = ST_FINISH;
               end
            endcase
         end

         ST_FILL: begin
            wr_en = 1'b1;
            if (cnt_ff == AW'(CELLS - 1)) begin
               cnt_in   = '0;
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end

         ST_SCR_RD: begin
            if (cnt_ff < AW'(SCROLL_CELLS)) begin
               rd_en    = 1'b1;
               state_in = ST_SCR_WR;
            end else begin
               // bottom row gets white-on-black blanks
               wr_en   = 1'b1;
               wr_data = tccs_pkg::BLANK_CELL;
               if (cnt_ff == AW'(CELLS - 1)) begin
                  cnt_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  cnt_in = cnt_ff + AW'(1);
               end
            end
         end

         ST_SCR_WR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            cnt_in   = cnt_ff + AW'(1);
            state_in = ST_SCR_RD;
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = 11'(pos_ff);
               rsp_row_in   = 5'(row_ff);
               rsp_col_in   = 7'(col_ff);
               rsp_scr_in   = scrolled_ff;
               rsp_word_in  = hit_ff ? rd_data : 16'h0000;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         pos_ff       <= '0;
         scrolled_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         pos_ff       <= pos_in;
         scrolled_ff  <= scrolled_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      ch_ff       <= ch_in;
      attr_ff     <= attr_in;
      idx_ff      <= idx_in;
      fill_ff     <= fill_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_scr_ff  <= rsp_scr_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cursor_row      = rsp_row_ff;
   assign rsp_cursor_column   = rsp_col_ff;
   assign rsp_scrolled        = rsp_scr_ff;
   assign rsp_cell_word       = rsp_word_ff;

endmodule
